[src/grid_raycast_column_core_defines.svh]
`ifndef GRID_RAYCAST_COLUMN_CORE_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_CORE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define RGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define RGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/rgc_pkg.sv]
`timescale 1ns / 1ps
package rgc_pkg;

  localparam int MAP_DIM_DEF    = 8;
  localparam int FRAC_BITS_DEF  = 12;
  localparam int ANGLE_BITS_DEF = 12;

  localparam int PLAYER_W = 15;
  localparam int DIM_W    = 12;

  // odd Horner coefficients of sin(pi/2 * x), Q30
  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598668;
  localparam logic [31:0] C5 = 32'd85569306;
  localparam logic [31:0] C7 = 32'd5026995;
  localparam logic [31:0] C9 = 32'd172271;

  localparam logic [13:0] LINE_SAT = 14'd8192;
  localparam logic [10:0] OUT_MAX  = 11'd2047;

  // register indexes
  localparam logic [2:0] REG_WALL_MAP      = 3'd0;
  localparam logic [2:0] REG_PLAYER_X      = 3'd1;
  localparam logic [2:0] REG_PLAYER_Y      = 3'd2;
  localparam logic [2:0] REG_VIEW_ANGLE    = 3'd3;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;

  typedef struct packed {
    logic done;      // quotient valid this cycle
    logic den_zero;  // divisor of that division was zero
  } rgc_div_status_t;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_ANG_DIV  = 10'b0000000010,
    S_SIN_MUL  = 10'b0000000100,
    S_SIN_UPD  = 10'b0000001000,
    S_DX_DIV   = 10'b0000010000,
    S_DY_DIV   = 10'b0000100000,
    S_SD_MUL   = 10'b0001000000,
    S_WALK     = 10'b0010000000,
    S_LINE_DIV = 10'b0100000000,
    S_FINISH   = 10'b1000000000
  } rgc_state_t;

endpackage

[src/rgc_div.sv]
`timescale 1ns / 1ps
module rgc_div #(
  parameter int NW  = 25,
  parameter int DVW = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [NW-1:0]            num,
  input  logic [DVW-1:0]           den,
  output logic [NW-1:0]            quot,
  output rgc_pkg::rgc_div_status_t status
);
  import rgc_pkg::*;

  localparam int CNTW = (NW > 1) ? $clog2(NW) : 1;

  logic [DVW-1:0]  rem;
  logic [DVW-1:0]  den_r;
  logic [NW-1:0]   quo;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done;
  logic            den_zero;
  logic [DVW:0]    trial;
  logic [DVW:0]    diff;
  logic            fits;

  // restoring, one quotient bit per cycle
  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNTW'(0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quo      <= num;
      den_r    <= den;
      den_zero <= (den == '0);
      cnt      <= CNTW'(NW - 1);
    end else if (busy) begin
      rem <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
      quo <= {quo[NW-2:0], fits};
      cnt <= cnt - CNTW'(1);
    end
  end

  assign quot            = quo;
  assign status.done     = done;
  assign status.den_zero = den_zero;

endmodule

[src/rgc_mul.sv]
`timescale 1ns / 1ps
module rgc_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic               clk,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic [AW+BW-1:0]   prod
);
  always_ff @(posedge clk) begin
    prod <= {{BW{1'b0}}, a} * {{AW{1'b0}}, b};
  end
endmodule

[src/grid_raycast_column_core.sv]
// Each column runs four divisions of NW = max(11+A, 2F+1, 12+F) bits and a walk of
//   1 to 4*MAP_DIM+4 steps on one shared restoring divider and one shared multiplier.
// One column at a time: in_ready is high only while idle, and a result stalled by
//   out_ready holds the block in S_FINISH. Reset (rst, synchronous, active high) clears
//   the sequencer and output valid and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps
module grid_raycast_column_core #(
  parameter int MAP_DIM    = rgc_pkg::MAP_DIM_DEF,
  parameter int FRAC_BITS  = rgc_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = rgc_pkg::ANGLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // column in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] column,
  // slice out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] column_out,
  output logic [10:0] draw_start,
  output logic [10:0] draw_end,
  output logic        hit_side
);
  import rgc_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int A    = ANGLE_BITS;
  localparam int CW0  = PLAYER_W - F + 2;
  localparam int CW   = (CW0 > 5) ? CW0 : 5;     // signed cell coordinate
  localparam int SW   = F + 1;                   // sine magnitude, up to 1.0
  localparam int DLW  = 2 * F + 3;               // delta distance
  localparam int DW   = 2 * F + 8;               // side distances over the walk
  localparam int NW0  = (11 + A > 2 * F + 1) ? 11 + A : 2 * F + 1;
  localparam int NW   = (NW0 > 12 + F) ? NW0 : 12 + F;
  localparam int MAW  = (DLW > 32) ? DLW : 32;
  localparam int PRW  = MAW + 32;
  localparam int NMAX = 4 * MAP_DIM + 4;
  localparam int NCW  = $clog2(NMAX);
  localparam logic [A-1:0]   QUARTER = A'(1) << (A - 2);
  localparam logic [31:0]    ANG_OFS = 32'((1 << A) - (1 << A) / 12);
  localparam logic [32:0]    RND     = 33'(1) << (29 - F);
  localparam logic [SW-1:0]  ONE_Q   = SW'(1) << F;
  localparam logic [DLW-1:0] DSAT    = DLW'(1) << (2 * F + 2);
  localparam logic signed [CW-1:0] CSTEP = CW'(1);
  localparam logic signed [CW-1:0] MAPC  = CW'(MAP_DIM);

  // ---- configuration registers ----
  logic [63:0]         wall_map;
  logic [PLAYER_W-1:0] player_x;
  logic [PLAYER_W-1:0] player_y;
  logic [11:0]         view_angle;
  logic [DIM_W-1:0]    screen_width;
  logic [DIM_W-1:0]    screen_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_map      <= '0;
      player_x      <= PLAYER_W'(6144);
      player_y      <= PLAYER_W'(6144);
      view_angle    <= '0;
      screen_width  <= DIM_W'(640);
      screen_height <= DIM_W'(480);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WALL_MAP:      wall_map      <= cfg_data;
        REG_PLAYER_X:      player_x      <= cfg_data[PLAYER_W-1:0];
        REG_PLAYER_Y:      player_y      <= cfg_data[PLAYER_W-1:0];
        REG_VIEW_ANGLE:    view_angle    <= cfg_data[11:0];
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- shared units ----
  logic             div_start;
  logic [NW-1:0]    div_num;
  logic [DW-1:0]    div_den;
  logic [NW-1:0]    div_quot;
  rgc_div_status_t  div_st;

  rgc_div #(.NW(NW), .DVW(DW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quot   (div_quot),
    .status (div_st)
  );

  logic [MAW-1:0] mul_a;
  logic [31:0]    mul_b;
  logic [PRW-1:0] prod;

  rgc_mul #(.AW(MAW), .BW(32)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // ---- sequencer and datapath registers ----
  rgc_state_t state, state_next;

  logic [10:0]      col_r;
  logic [A-1:0]     ang_r;
  logic             sin_sel;     // 0 working on x (cosine), 1 on y (sine)
  logic [2:0]       k;
  logic [30:0]      x_r;
  logic [30:0]      x2_r;
  logic [31:0]      p_r;
  logic [SW-1:0]    rx, ry;
  logic             negx, negy;
  logic [DLW-1:0]   dx, dy;
  logic [DW-1:0]    sdx, sdy;
  logic signed [CW-1:0] mx, my;
  logic             side;
  logic [NCW-1:0]   n;
  logic [13:0]      line_r;

  function automatic logic [30:0] fold_x(input logic [A-1:0] a);
    logic [A-3:0] r;
    logic [A-2:0] t;
    r = a[A-3:0];
    t = a[A-2] ? (A-1)'(QUARTER) - (A-1)'(r) : (A-1)'(r);
    return 31'(t) << (32 - A);
  endfunction

  // angle of this ray from the column division
  logic [31:0]  ang_sum;
  logic [A-1:0] ang_c;
  logic [A-1:0] cang_c;
  assign ang_sum = 32'(view_angle) + 32'(div_quot) + ANG_OFS;
  assign ang_c   = ang_sum[A-1:0];
  assign cang_c  = ang_c + QUARTER;

  // end of the sine polynomial: round to F fraction bits, cap at 1.0
  logic [31:0]   pf;
  logic [32:0]   rnd_sum;
  logic [32:0]   rnd_sh;
  logic [SW-1:0] sin_val;
  assign pf      = prod[61:30];
  assign rnd_sum = 33'(pf) + RND;
  assign rnd_sh  = rnd_sum >> (30 - F);
  assign sin_val = (rnd_sh > 33'(ONE_Q)) ? ONE_Q : rnd_sh[SW-1:0];

  logic sxn, syn;
  assign sxn = negx && (rx != '0);
  assign syn = negy && (ry != '0);

  logic [SW-1:0] frac_x, frac_y;
  assign frac_x = sxn ? SW'(player_x[F-1:0]) : ONE_Q - SW'(player_x[F-1:0]);
  assign frac_y = syn ? SW'(player_y[F-1:0]) : ONE_Q - SW'(player_y[F-1:0]);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_SIN_MUL) begin
      case (k)
        3'd0:    begin mul_a = MAW'(x_r); mul_b = 32'(x_r);  end
        3'd1:    begin mul_a = MAW'(C9);  mul_b = 32'(x2_r); end
        3'd5:    begin mul_a = MAW'(p_r); mul_b = 32'(x_r);  end
        default: begin mul_a = MAW'(p_r); mul_b = 32'(x2_r); end
      endcase
    end else if (state == S_SD_MUL) begin
      if (k == 3'd0) begin
        mul_a = MAW'(dx);
        mul_b = 32'(frac_x);
      end else begin
        mul_a = MAW'(dy);
        mul_b = 32'(frac_y);
      end
    end
  end

  logic [31:0] poly_c;
  always_comb begin
    case (k)
      3'd1:    poly_c = C7;
      3'd2:    poly_c = C5;
      3'd3:    poly_c = C3;
      default: poly_c = C1;
    endcase
  end

  // one DDA step: compare, add, and test the cell it enters
  logic                 step_x;
  logic signed [CW-1:0] mx_n, my_n;
  logic                 wall_hit;
  logic                 walk_end;
  assign step_x = (sdx < sdy);
  assign mx_n   = step_x ? (sxn ? mx - CSTEP : mx + CSTEP) : mx;
  assign my_n   = step_x ? my : (syn ? my - CSTEP : my + CSTEP);
  always_comb begin
    if (mx_n < 0 || my_n < 0 || mx_n >= MAPC || my_n >= MAPC) begin
      wall_hit = 1'b1;
    end else begin
      wall_hit = wall_map[{mx_n[2:0], my_n[2:0]}];
    end
  end
  assign walk_end = wall_hit || (n == NCW'(NMAX - 1));

  logic out_load;
  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_ANG_DIV;
      S_ANG_DIV:  if (div_st.done) state_next = S_SIN_MUL;
      S_SIN_MUL:  state_next = S_SIN_UPD;
      S_SIN_UPD: begin
        if (k == 3'd5 && sin_sel) state_next = S_DX_DIV;
        else state_next = S_SIN_MUL;
      end
      S_DX_DIV:   if (div_st.done) state_next = S_DY_DIV;
      S_DY_DIV:   if (div_st.done) state_next = S_SD_MUL;
      S_SD_MUL:   if (k == 3'd2) state_next = S_WALK;
      S_WALK:     if (walk_end) state_next = S_LINE_DIV;
      S_LINE_DIV: if (div_st.done) state_next = S_FINISH;
      S_FINISH:   if (out_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
    end else begin
      state     <= state_next;
      div_start <= 1'b0;
      case (state)
        S_IDLE:     if (in_valid) div_start <= 1'b1;
        S_SIN_UPD:  if (k == 3'd5 && sin_sel) div_start <= 1'b1;
        S_DX_DIV:   if (div_st.done) div_start <= 1'b1;
        S_WALK:     if (walk_end) div_start <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        col_r   <= column;
        div_num <= NW'(column) << A;
        div_den <= DW'(15'(screen_width == '0 ? DIM_W'(1) : screen_width) * 15'(6));
      end
      S_ANG_DIV: begin
        if (div_st.done) begin
          ang_r   <= ang_c;
          x_r     <= fold_x(cang_c);
          negx    <= cang_c[A-1];
          negy    <= ang_c[A-1];
          sin_sel <= 1'b0;
          k       <= 3'd0;
        end
      end
      S_SIN_UPD: begin
        case (k)
          3'd0:    x2_r <= prod[60:30];
          3'd5:    ;
          default: p_r <= poly_c - prod[61:30];
        endcase
        if (k == 3'd5) begin
          k <= 3'd0;
          if (!sin_sel) begin
            rx      <= sin_val;
            sin_sel <= 1'b1;
            x_r     <= fold_x(ang_r);
          end else begin
            ry      <= sin_val;
            div_num <= NW'(1) << (2 * F);
            div_den <= DW'(rx);
          end
        end else begin
          k <= k + 3'd1;
        end
      end
      S_DX_DIV: begin
        if (div_st.done) begin
          dx      <= div_st.den_zero ? DSAT : DLW'(div_quot);
          div_den <= DW'(ry);
        end
      end
      S_DY_DIV: begin
        if (div_st.done) begin
          dy <= div_st.den_zero ? DSAT : DLW'(div_quot);
          k  <= 3'd0;
          mx <= CW'(player_x[PLAYER_W-1:F]);
          my <= CW'(player_y[PLAYER_W-1:F]);
        end
      end
      S_SD_MUL: begin
        if (k == 3'd1) sdx <= DW'(prod >> F);
        if (k == 3'd2) begin
          sdy <= DW'(prod >> F);
          n   <= '0;
        end
        k <= k + 3'd1;
      end
      S_WALK: begin
        // the stepped side distance before its add is the perpendicular distance
        if (step_x) sdx <= sdx + DW'(dx);
        else        sdy <= sdy + DW'(dy);
        mx   <= mx_n;
        my   <= my_n;
        side <= !step_x;
        n    <= n + NCW'(1);
        if (walk_end) begin
          div_num <= NW'(screen_height) << F;
          div_den <= step_x ? sdx : sdy;
        end
      end
      S_LINE_DIV: begin
        if (div_st.done) begin
          if (div_st.den_zero || div_quot > NW'(LINE_SAT)) line_r <= LINE_SAT;
          else line_r <= div_quot[13:0];
        end
      end
      default: ;
    endcase
  end

  // ---- slice rows and output register ----
  logic [10:0] half_h;
  logic [12:0] half_l;
  logic [13:0] end_sum;
  logic [11:0] h_last;
  logic [13:0] de_w;
  logic [10:0] ds_c, de_c;
  assign half_h  = screen_height[11:1];
  assign half_l  = line_r[13:1];
  assign end_sum = 14'(half_l) + 14'(half_h);
  assign h_last  = (screen_height == '0) ? 12'd0 : screen_height - 12'd1;
  assign de_w    = (end_sum > 14'(h_last)) ? 14'(h_last) : end_sum;
  assign ds_c    = (half_l >= 13'(half_h)) ? 11'd0 : half_h - half_l[10:0];
  assign de_c    = (de_w > 14'(OUT_MAX)) ? OUT_MAX : de_w[10:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      column_out <= col_r;
      draw_start <= ds_c;
      draw_end   <= de_c;
      hit_side   <= side;
    end
  end

endmodule

[src/rgc_checker.sv]
`timescale 1ns / 1ps
`include "grid_raycast_column_core_defines.svh"
module rgc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] column_out,
  input logic [10:0] draw_start,
  input logic [10:0] draw_end,
  input logic        hit_side
);
  logic [33:0] out_word;
  assign out_word = {column_out, draw_start, draw_end, hit_side};

  // a stalled result holds
  `RGC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "stalled result changed")
  // the slice never runs upward
  `RGC_ASSERT_NOW(a_slice_order, out_valid, draw_start <= draw_end, "draw_start above draw_end")
  // a transfer in starts work, so the block goes busy
  `RGC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready stayed high after transfer")
  // a new result only comes from a busy block
  `RGC_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(!in_ready), "result without work")
endmodule

bind grid_raycast_column_core rgc_checker u_rgc_checker (.*);
